// ===== rtl/aes_pkg.sv =====
// shared types, constants and byte functions for the aes-128 block encryptor
// no dependencies; imported by every module of the block
package aes_pkg;

   // cipher shape
   localparam int KEY_WORDS   = 4;
   localparam int ROUND_COUNT = 10;
   localparam int RND_W       = $clog2(ROUND_COUNT + 1);
   localparam logic [RND_W-1:0] FIRST_RND = RND_W'(1);
   localparam logic [RND_W-1:0] LAST_RND  = RND_W'(ROUND_COUNT);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = CSR_IDX_W'(1);

   // field constants
   localparam logic [7:0] GF_POLY   = 8'h1b;
   localparam logic [7:0] RCON_INIT = 8'h01;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_payload_type;

   typedef enum logic {
      ENC_IDLE,
      ENC_RUN
   } enc_state_type;

   // key schedule status seen by the controller
   typedef struct packed {
      logic busy;
   } kx_status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic logic [7:0] sbox(input logic [7:0] b);
      return SBOX[b];
   endfunction

   // multiply by x in gf(2^8)
   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

endpackage

// ===== rtl/aes_col_lane.sv =====
// one column lane: substitution, optional column mix and round key add
// depends on aes_pkg for the s-box and xtime
module aes_col_lane
   import aes_pkg::*;
(
   input  logic [31:0] col_in,
   input  logic [31:0] key_word,
   input  logic        mix_en,
   output logic [31:0] col_out
);

   logic [7:0] a0, a1, a2, a3, all;
   logic [31:0] mixed;

   // byte substitution, top byte is row 0
   assign a0 = sbox(col_in[31:24]);
   assign a1 = sbox(col_in[23:16]);
   assign a2 = sbox(col_in[15:8]);
   assign a3 = sbox(col_in[7:0]);

   // column mix
   assign all   = a0 ^ a1 ^ a2 ^ a3;
   assign mixed = {a0 ^ all ^ xtime(a0 ^ a1),
                   a1 ^ all ^ xtime(a1 ^ a2),
                   a2 ^ all ^ xtime(a2 ^ a3),
                   a3 ^ all ^ xtime(a3 ^ a0)};

   // round key add
   assign col_out = (mix_en ? mixed : {a0, a1, a2, a3}) ^ key_word;

endmodule

// ===== rtl/aes_round.sv =====
// one cipher round: row shift routing into four column lanes, merged back into a state
// depends on aes_pkg and aes_col_lane
module aes_round
   import aes_pkg::*;
(
   input  logic [127:0] state_in,
   input  logic [127:0] rnd_key,
   input  logic         final_round,
   output logic [127:0] state_out
);

   logic [7:0]  st_byte  [16];
   logic [31:0] lane_in  [KEY_WORDS];
   logic [31:0] lane_out [KEY_WORDS];

   // byte i of the state sits i bytes below the top end of the word
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         st_byte[i] = state_in[127 - 8*i -: 8];
      end
   end

   // row shift: row r of column c comes from column c + r
   always_comb begin
      for (int c = 0; c < KEY_WORDS; c++) begin
         for (int r = 0; r < 4; r++) begin
            lane_in[c][31 - 8*r -: 8] = st_byte[4*((c + r) % 4) + r];
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < KEY_WORDS; g++) begin : g_lane
         aes_col_lane u_lane (
            .col_in   (lane_in[g]),
            .key_word (rnd_key[127 - 32*g -: 32]),
            .mix_en   (!final_round),
            .col_out  (lane_out[g])
         );
      end
   endgenerate

   // merge lane results into the next state
   always_comb begin
      for (int c = 0; c < KEY_WORDS; c++) begin
         state_out[127 - 32*c -: 32] = lane_out[c];
      end
   end

endmodule

// ===== rtl/aes_key_sched.sv =====
// key expansion sequencer and round key memory, one round key per cycle
// depends on aes_pkg
module aes_key_sched
   import aes_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [127:0]       cipher_key,
   input  logic [RND_W-1:0]   rd_addr,
   output logic [127:0]       rd_key,
   output kx_status_type      status
);

   logic [127:0]     rk_mem [ROUND_COUNT + 1];
   logic [127:0]     rd_key_ff;
   logic             busy_ff, busy_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic [7:0]       rcon_ff, rcon_in;
   logic [127:0]     prev_ff;
   logic [127:0]     cur_key;
   logic [31:0]      t_word, n0, n1, n2, n3;

   // next round key from the previous one
   assign t_word = sub_word({prev_ff[23:0], prev_ff[31:24]}) ^ {rcon_ff, 24'h000000};
   assign n0 = prev_ff[127:96] ^ t_word;
   assign n1 = prev_ff[95:64] ^ n0;
   assign n2 = prev_ff[63:32] ^ n1;
   assign n3 = prev_ff[31:0] ^ n2;
   assign cur_key = (rnd_ff == '0) ? cipher_key : {n0, n1, n2, n3};

   // sequencer control
   always_comb begin
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      rcon_in = rcon_ff;
      if (start) begin
         busy_in = 1'b1;
         rnd_in  = '0;
      end else if (busy_ff) begin
         rcon_in = (rnd_ff == '0) ? RCON_INIT : xtime(rcon_ff);
         if (rnd_ff == LAST_RND) begin
            busy_in = 1'b0;
         end else begin
            rnd_in = rnd_ff + RND_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         rnd_ff  <= rnd_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rcon_ff <= rcon_in;
      if (busy_ff && !start) begin
         prev_ff <= cur_key;
      end
   end

   // round key memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         rk_mem[rnd_ff] <= cur_key;
      end
      rd_key_ff <= rk_mem[rd_addr];
   end

   assign rd_key      = rd_key_ff;
   assign status.busy = busy_ff;

   // checks
   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rnd_ff <= LAST_RND)
      else $error("key schedule round out of range");
   a_start: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && rnd_ff == '0)
      else $error("key schedule did not restart");
   a_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(rnd_ff) == LAST_RND)
      else $error("key schedule ended early");

endmodule

// ===== rtl/aes128_block_encrypt.sv =====
// top level of the aes-128 block encryptor: key registers, round controller, result register
// depends on aes_pkg, aes_key_sched and aes_round
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_payload (block_high, block_low)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_payload (cipher_high, cipher_low)
//  csr     | in        | csr_we                 | csr_index, csr_wdata (key_high, key_low)
//
// an item gets the first key add at acceptance, then ten rounds through one shared round
// unit, one round per cycle but for a stalled last round, paced by the round key read.
// no new item is taken while rounds run; one can be taken in the cycle the result shows.
// a key write expands the key into the round key memory; while it runs, req_stall is high.
// reset is synchronous and clears control state and the key registers, not the round key
// memory; a key must be written before use.
// a stalled result holds the last round until the result register frees.
module aes128_block_encrypt
   import aes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   enc_state_type    state_ff, state_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic [63:0]      key_high_ff, key_low_ff;
   logic [127:0]     blk_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff;
   logic             load, advance, final_round, out_free, kx_start;
   logic [RND_W-1:0] rd_addr;
   logic [127:0]     rnd_key, round_out;
   kx_status_type    kx_status;

   // key registers
   assign kx_start = csr_we && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_KEY_HIGH) begin
            key_high_ff <= csr_wdata;
         end
         if (csr_index == CSR_KEY_LOW) begin
            key_low_ff <= csr_wdata;
         end
      end
   end

   aes_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .start      (kx_start),
      .cipher_key ({key_high_ff, key_low_ff}),
      .rd_addr    (rd_addr),
      .rd_key     (rnd_key),
      .status     (kx_status)
   );

   aes_round u_round (
      .state_in    (blk_ff),
      .rnd_key     (rnd_key),
      .final_round (final_round),
      .state_out   (round_out)
   );

   // controller outputs
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign final_round = (rnd_ff == LAST_RND);

   always_comb begin
      req_stall = 1'b1;
      advance   = 1'b0;
      case (state_ff)
         ENC_IDLE: begin
            req_stall = kx_status.busy || csr_we;
         end
         ENC_RUN: begin
            advance = !final_round || out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign load = req_valid && !req_stall;

   // round key read address, one round ahead
   always_comb begin
      if (load) begin
         rd_addr = FIRST_RND;
      end else if (advance && !final_round) begin
         rd_addr = rnd_ff + RND_W'(1);
      end else begin
         rd_addr = rnd_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      case (state_ff)
         ENC_IDLE: begin
            if (load) begin
               state_in = ENC_RUN;
               rnd_in   = FIRST_RND;
            end
         end
         ENC_RUN: begin
            if (advance) begin
               if (final_round) begin
                  state_in = ENC_IDLE;
               end else begin
                  rnd_in = rnd_ff + RND_W'(1);
               end
            end
         end
         default: begin
            state_in = ENC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENC_IDLE;
         rnd_ff   <= FIRST_RND;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
      end
   end

   // block state: first key add on load, one round per advance
   always_ff @(posedge clock) begin
      if (load) begin
         blk_ff <= {req_payload.block_high, req_payload.block_low} ^
                   {key_high_ff, key_low_ff};
      end else if (advance) begin
         blk_ff <= round_out;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance && final_round) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && final_round) begin
         rsp_data_ff <= round_out;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // checks
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> state_ff == ENC_RUN && rnd_ff == FIRST_RND)
      else $error("item accepted without starting the rounds");
   a_no_run_in_kx: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ENC_RUN && kx_status.busy))
      else $error("rounds running during key expansion");
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      advance && final_round |=> rsp_valid_ff)
      else $error("finished item not shown");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      advance && final_round |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

endmodule
